// ----- rtl/wft_pkg.sv -----
// shared types, constants and the transform row function of the winograd filter transform
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package wft_pkg;

    localparam int TAP_W        = 16;
    localparam int N_TAPS       = 9;
    localparam int IDX_W        = 9;
    localparam int REG_W        = 10;
    localparam int MAX_CHANNELS = 512;
    localparam int CK_W         = 19;
    localparam int BASE_W       = 18;
    localparam int ADDR_W       = 24;
    localparam int T_W          = 22;
    localparam int S_W          = 27;
    localparam int U_W          = 19;
    localparam int RECIP_W      = 21;
    localparam int RECIP_SH     = 24;
    localparam int IN_W         = 168;
    localparam int OUT_W        = 48;

    // 576 = 64 * 9: shift by 6, then multiply by ceil(2^24 / 9)
    localparam logic [RECIP_W-1:0] RECIP    = 21'd1864136;
    localparam logic [S_W-1:0]     HALF_SQ  = 27'd288;
    localparam logic [2:0]         LAST_IDX = 3'd5;

    localparam logic REG_OUT_CH = 1'b0;
    localparam logic REG_IN_CH  = 1'b1;

    typedef struct packed {
        logic [N_TAPS-1:0][TAP_W-1:0] taps;
        logic [BASE_W-1:0]            base;
        logic [CK_W-1:0]              ck;
    } t_job;

    typedef struct packed {
        logic [2:0]        row;
        logic [2:0]        col;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } t_meta;

    // one row of the transform matrix scaled by 24, applied to three values
    function automatic logic signed [S_W-1:0] row_mix(
        input logic [2:0]            sel,
        input logic signed [S_W-1:0] x0,
        input logic signed [S_W-1:0] x1,
        input logic signed [S_W-1:0] x2
    );
        logic signed [S_W-1:0] r;
        unique case (sel)
            3'd0:    r = (x0 <<< 2) + (x0 <<< 1);
            3'd1:    r = -((x0 + x1 + x2) <<< 2);
            3'd2:    r = (x1 - x0 - x2) <<< 2;
            3'd3:    r = x0 + (x1 <<< 1) + (x2 <<< 2);
            3'd4:    r = x0 - (x1 <<< 1) + (x2 <<< 2);
            3'd5:    r = (x2 <<< 4) + (x2 <<< 3);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/wft_front.sv -----
// front end: channel-count registers, input acceptance and job assembly
// depends on wft_pkg
`timescale 1ns / 1ps
`default_nettype none

module wft_front
    import wft_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [REG_W-1:0]  i_cfg_data,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [IN_W-1:0]   i_s_tdata,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output t_job                   o_job
);

    logic [REG_W-1:0] r_out_ch, n_out_ch;
    logic [REG_W-1:0] r_in_ch, n_in_ch;
    logic [REG_W-1:0] w_clamped;
    logic [IDX_W-1:0] w_k;
    logic [IDX_W-1:0] w_c;
    logic [2*REG_W-1:0] w_ck;
    logic [IDX_W+REG_W-1:0] w_ckoff;

    assign w_clamped = (i_cfg_data > REG_W'(MAX_CHANNELS)) ? REG_W'(MAX_CHANNELS) : i_cfg_data;

    always_comb begin
        n_out_ch = r_out_ch;
        n_in_ch  = r_in_ch;
        if (i_cfg_we) begin
            priority if (i_cfg_index == REG_OUT_CH) begin
                n_out_ch = w_clamped;
            end else if (i_cfg_index == REG_IN_CH) begin
                n_in_ch = w_clamped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_ch <= REG_W'(256);
            r_in_ch  <= REG_W'(256);
        end else begin
            r_out_ch <= n_out_ch;
            r_in_ch  <= n_in_ch;
        end
    end

    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full;

    assign w_k     = i_s_tdata[N_TAPS*TAP_W +: IDX_W];
    assign w_c     = i_s_tdata[N_TAPS*TAP_W+IDX_W +: IDX_W];
    assign w_ck    = r_in_ch * r_out_ch;
    assign w_ckoff = w_c * r_out_ch;

    always_comb begin
        for (int t = 0; t < N_TAPS; t++) begin
            o_job.taps[t] = i_s_tdata[t*TAP_W +: TAP_W];
        end
        // c*K + k stays below 2^18 with clamped registers
        o_job.base = BASE_W'(w_ckoff + (IDX_W+REG_W)'(w_k));
        o_job.ck   = w_ck[CK_W-1:0];
    end

endmodule

`default_nettype wire

// ----- rtl/wft_queue.sv -----
// two-entry job queue between the front end and the transform back end
// depends on wft_pkg
`timescale 1ns / 1ps
`default_nettype none

module wft_queue
    import wft_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    t_job       r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_comb begin
        n_wp    = r_wp ^ i_push;
        n_rp    = r_rp ^ i_pop;
        n_count = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/wft_back.sv -----
// back end: walks the 36 tile elements of the head job through a four-stage pipeline
// depends on wft_pkg
`timescale 1ns / 1ps
`default_nettype none

module wft_back
    import wft_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  t_job                   i_job,
    output logic                   o_pop,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [OUT_W-1:0]       o_m_tdata,
    output logic                   o_m_tlast
);

    logic w_en;
    logic w_issue;

    logic [2:0]        r_i, n_i;
    logic [2:0]        r_j, n_j;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [ADDR_W-1:0] w_addr;
    logic              w_last;

    // stage 1: one row of G*g
    logic                  r_v1;
    t_meta                 r_m1;
    logic signed [T_W-1:0] r_t [3];
    // stage 2: magnitude after the divide by 64
    logic                  r_v2;
    t_meta                 r_m2;
    logic                  r_neg2;
    logic [U_W-1:0]        r_u;
    // stage 3: quotient magnitude
    logic                  r_v3;
    t_meta                 r_m3;
    logic                  r_neg3;
    logic [TAP_W-1:0]      r_q;
    // output register
    logic                  r_vo;
    logic [OUT_W-1:0]      r_data;
    logic                  r_lasto;

    logic signed [S_W-1:0]         w_g [N_TAPS];
    logic signed [S_W-1:0]         w_row [3];
    logic signed [S_W-1:0]         w_s;
    logic [S_W-1:0]                w_abs;
    logic [S_W-1:0]                w_rnd;
    logic [U_W+RECIP_W-1:0]        w_prod;
    logic [TAP_W-1:0]              w_val;

    assign w_en    = !r_vo || i_m_tready;
    assign w_issue = w_en && i_q_valid;
    assign w_last  = (r_i == LAST_IDX) && (r_j == LAST_IDX);
    assign o_pop   = w_issue && w_last;
    // consecutive elements are one C*K apart in row-major order
    assign w_addr  = (r_i == 3'd0 && r_j == 3'd0) ? ADDR_W'(i_job.base) : r_addr;

    always_comb begin
        n_i    = r_i;
        n_j    = r_j;
        n_addr = r_addr;
        if (w_issue) begin
            n_addr = w_addr + ADDR_W'(i_job.ck);
            if (r_j == LAST_IDX) begin
                n_j = 3'd0;
                n_i = (r_i == LAST_IDX) ? 3'd0 : r_i + 3'd1;
            end else begin
                n_j = r_j + 3'd1;
            end
        end
    end

    always_comb begin
        for (int t = 0; t < N_TAPS; t++) begin
            w_g[t] = S_W'(signed'(i_job.taps[t]));
        end
        for (int b = 0; b < 3; b++) begin
            w_row[b] = row_mix(r_i, w_g[b], w_g[3+b], w_g[6+b]);
        end
    end

    assign w_s    = row_mix(r_m1.col, S_W'(r_t[0]), S_W'(r_t[1]), S_W'(r_t[2]));
    assign w_abs  = w_s[S_W-1] ? S_W'(-w_s) : S_W'(w_s);
    assign w_rnd  = w_abs + HALF_SQ;
    assign w_prod = (U_W+RECIP_W)'(r_u) * (U_W+RECIP_W)'(RECIP);
    assign w_val  = r_neg3 ? TAP_W'(-r_q) : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i    <= 3'd0;
            r_j    <= 3'd0;
            r_addr <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_vo   <= 1'b0;
        end else begin
            r_i    <= n_i;
            r_j    <= n_j;
            r_addr <= n_addr;
            if (w_en) begin
                r_v1 <= i_q_valid;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_vo <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1.row  <= r_i;
            r_m1.col  <= r_j;
            r_m1.addr <= w_addr;
            r_m1.last <= w_last;
            for (int b = 0; b < 3; b++) begin
                r_t[b] <= T_W'(w_row[b]);
            end
            r_m2   <= r_m1;
            r_neg2 <= w_s[S_W-1];
            r_u    <= w_rnd[U_W+5:6];
            r_m3   <= r_m2;
            r_neg3 <= r_neg2;
            r_q    <= w_prod[RECIP_SH +: TAP_W];
            r_data <= {2'b00, r_m3.addr, r_m3.col, r_m3.row, w_val};
            r_lasto <= r_m3.last;
        end
    end

    assign o_m_tvalid = r_vo;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_lasto;

endmodule

`default_nettype wire

// ----- rtl/winograd_filter_transform_3x3.sv -----
// winograd F(4x4,3x3) filter transform: 3x3 filter in, 36 tile elements out
// depends on wft_pkg, wft_front, wft_queue, wft_back
//
// usage:
//   slave channel takes one filter per item: nine Q3.12 weights, output and
//   input channel index. master channel gives 36 items per filter in
//   row-major tile order, each with its value, row, column and HWCK address;
//   tlast marks the 36th.
//   config port writes K (index 0) and C (index 1), clamped to 512, while idle.
// timing:
//   results pass the job queue, the back pipeline and its output register.
//   one result per cycle while the output is not stalled; this is set by the
//   element sequencer of the back end, which issues one tile element a cycle.
//   a two-entry job queue holds the filter in work plus one waiting filter.
// reset:
//   synchronous, active low; empties queue and pipeline, K and C return to 256.
// stall:
//   when the receiver holds tready low on a valid result the output holds and the back
//   pipeline freezes; the slave side keeps taking filters until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module winograd_filter_transform_3x3
    import wft_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [REG_W-1:0]  i_cfg_data,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    // tap_00, tap_01, tap_02, tap_10, tap_11, tap_12, tap_20, tap_21, tap_22,
    // out_channel_index, in_channel_index, zero fill
    input  wire logic [IN_W-1:0]   i_s_tdata,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    // tile_value, tile_row, tile_col, dest_address, zero fill
    output logic [OUT_W-1:0]       o_m_tdata,
    output logic                   o_m_tlast
);

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_qvalid;
    t_job w_in_job;
    t_job w_head_job;

    wft_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_job      (w_in_job)
    );

    wft_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_job  (w_in_job),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_valid(w_qvalid),
        .o_job  (w_head_job)
    );

    wft_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_qvalid),
        .i_job     (w_head_job),
        .o_pop     (w_pop),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/wft_checker.sv -----
// port-level checks for the winograd filter transform, bound to the top level
// depends on wft_pkg
`timescale 1ns / 1ps
`default_nettype none

module wft_checker
    import wft_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_m_tvalid,
    input wire logic             i_m_tready,
    input wire logic [OUT_W-1:0] o_m_tdata,
    input wire logic             o_m_tlast
);

    // reset empties the pipeline by the next edge
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // tlast exactly on the corner element of the tile
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == ((o_m_tdata[18:16] == 3'd5) && (o_m_tdata[21:19] == 3'd5))))
        else $error("tlast not on the last tile element");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[18:16] <= 3'd5) && (o_m_tdata[21:19] <= 3'd5)
                       && (o_m_tdata[47:46] == 2'b00))
        else $error("tile index out of range or fill bits set");

endmodule

bind winograd_filter_transform_3x3 wft_checker u_wft_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tlast (o_m_tlast)
);

`default_nettype wire
